/* rtl/caim_pkg.sv */
`default_nettype none

package caim_pkg;

  // Fixed field widths of the interface.
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int REPORT_W    = 16;

  // Default coordinate width (unsigned Q12.4 pixels).
  localparam int COORD_BITS_DEF = 16;

  // Quotient bits of the clipped ratio (Q1.16 fraction).
  localparam int QUOT_BITS   = 16;

  // Reset values of the aim point registers.
  localparam logic [CFG_W-1:0] AIM_COL_RESET = 16'd5120;
  localparam logic [CFG_W-1:0] AIM_ROW_RESET = 16'd3840;

  // One in Q1.16 and the report full scale.
  localparam logic [QUOT_BITS:0] UNIT_Q     = 17'd65536;
  localparam int                 REPORT_FULL = 32767;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AIM_COL = 2'd0,
    CFG_AIM_ROW = 2'd1
  } caim_cfg_idx_t;

  // Special case flags that travel with an item through the divider.
  typedef struct packed {
    logic degen;
    logic u_zero;
    logic u_one;
    logic v_zero;
    logic v_one;
  } caim_flags_t;

endpackage

`default_nettype wire

/* rtl/caim_solve.sv */
`default_nettype none

// Five stage front end: offsets, six products, determinant and numerators,
// magnitudes with sign classification, then the at-or-beyond-one compare.
module caim_solve #(
  parameter int COORD_BITS = caim_pkg::COORD_BITS_DEF,
  parameter int MAG_W      = 2 * COORD_BITS + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [COORD_BITS-1:0]   aim_col,
  input  wire logic [COORD_BITS-1:0]   aim_row,
  input  wire logic [COORD_BITS-1:0]   origin_col,
  input  wire logic [COORD_BITS-1:0]   origin_row,
  input  wire logic [COORD_BITS-1:0]   xaxis_col,
  input  wire logic [COORD_BITS-1:0]   xaxis_row,
  input  wire logic [COORD_BITS-1:0]   yaxis_col,
  input  wire logic [COORD_BITS-1:0]   yaxis_row,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [MAG_W-1:0]             out_dmag,
  output logic [MAG_W-1:0]             out_umag,
  output logic [MAG_W-1:0]             out_vmag,
  output caim_pkg::caim_flags_t        out_flags
);
  import caim_pkg::*;

  localparam int NSTG   = 5;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   en;
  logic [NSTG-1:0] v_in;

  // A stage loads when it is empty or its contents move on.
  assign en[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign v_in = {v_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  // Stage 1: basis vectors and aim offset relative to the origin marker.
  logic signed [DIFF_W-1:0] ac_r, ar_r, bc_r, br_r, dc_r, dr_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ac_r <= $signed({1'b0, xaxis_col}) - $signed({1'b0, origin_col});
      ar_r <= $signed({1'b0, xaxis_row}) - $signed({1'b0, origin_row});
      bc_r <= $signed({1'b0, yaxis_col}) - $signed({1'b0, origin_col});
      br_r <= $signed({1'b0, yaxis_row}) - $signed({1'b0, origin_row});
      dc_r <= $signed({1'b0, aim_col})   - $signed({1'b0, origin_col});
      dr_r <= $signed({1'b0, aim_row})   - $signed({1'b0, origin_row});
    end
  end

  // Stage 2: the six cross products.
  logic signed [PROD_W-1:0] p_acbr_r, p_bcar_r, p_brdc_r, p_bcdr_r, p_acdr_r, p_ardc_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_acbr_r <= PROD_W'(ac_r) * PROD_W'(br_r);
      p_bcar_r <= PROD_W'(bc_r) * PROD_W'(ar_r);
      p_brdc_r <= PROD_W'(br_r) * PROD_W'(dc_r);
      p_bcdr_r <= PROD_W'(bc_r) * PROD_W'(dr_r);
      p_acdr_r <= PROD_W'(ac_r) * PROD_W'(dr_r);
      p_ardc_r <= PROD_W'(ar_r) * PROD_W'(dc_r);
    end
  end

  // Stage 3: determinant and the two numerators.
  logic signed [SUM_W-1:0] det_r, nu_r, nv_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      det_r <= SUM_W'(p_acbr_r) - SUM_W'(p_bcar_r);
      nu_r  <= SUM_W'(p_brdc_r) - SUM_W'(p_bcdr_r);
      nv_r  <= SUM_W'(p_acdr_r) - SUM_W'(p_ardc_r);
    end
  end

  // Stage 4: magnitudes, zero determinant and the clip-to-zero cases.
  logic signed [SUM_W-1:0] det_abs, nu_abs, nv_abs;
  logic [MAG_W-1:0]        dmag_r, umag_r, vmag_r;
  caim_flags_t             flg4_nxt, flg4_r;

  always_comb begin
    det_abs = det_r[SUM_W-1] ? -det_r : det_r;
    nu_abs  = nu_r[SUM_W-1]  ? -nu_r  : nu_r;
    nv_abs  = nv_r[SUM_W-1]  ? -nv_r  : nv_r;
    flg4_nxt        = '0;
    flg4_nxt.degen  = (det_r == '0);
    flg4_nxt.u_zero = (nu_r == '0) || (nu_r[SUM_W-1] != det_r[SUM_W-1]);
    flg4_nxt.v_zero = (nv_r == '0) || (nv_r[SUM_W-1] != det_r[SUM_W-1]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dmag_r <= det_abs[MAG_W-1:0];
      umag_r <= nu_abs[MAG_W-1:0];
      vmag_r <= nv_abs[MAG_W-1:0];
      flg4_r <= flg4_nxt;
    end
  end

  // Stage 5: a ratio at or beyond one saturates to one.
  caim_flags_t flg5_nxt;

  always_comb begin
    flg5_nxt       = flg4_r;
    flg5_nxt.u_one = !flg4_r.u_zero && (umag_r >= dmag_r);
    flg5_nxt.v_one = !flg4_r.v_zero && (vmag_r >= dmag_r);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      out_dmag  <= dmag_r;
      out_umag  <= umag_r;
      out_vmag  <= vmag_r;
      out_flags <= flg5_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/caim_divider.sv */
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage, u and v side by
// side over a shared divisor. The flags ride along unchanged.
module caim_divider #(
  parameter int MAG_W = 2 * caim_pkg::COORD_BITS_DEF + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [MAG_W-1:0]              in_dmag,
  input  wire logic [MAG_W-1:0]              in_umag,
  input  wire logic [MAG_W-1:0]              in_vmag,
  input  wire caim_pkg::caim_flags_t         in_flags,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [caim_pkg::QUOT_BITS-1:0]     out_qu,
  output logic [caim_pkg::QUOT_BITS-1:0]     out_qv,
  output caim_pkg::caim_flags_t              out_flags
);
  import caim_pkg::*;

  localparam int NSTG = QUOT_BITS;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   en;
  logic [NSTG-1:0] v_in;

  // Bubble-collapsing handshake along the stages.
  assign en[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign v_in = {v_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  logic [MAG_W-1:0]     ru_r [NSTG];
  logic [MAG_W-1:0]     rv_r [NSTG];
  logic [MAG_W-1:0]     dd_r [NSTG];
  logic [NSTG-1:0]      qu_r [NSTG];
  logic [NSTG-1:0]      qv_r [NSTG];
  caim_flags_t          fl_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_step
    logic [MAG_W-1:0] ru_in, rv_in, dd_in;
    logic [NSTG-1:0]  qu_in, qv_in;
    caim_flags_t      fl_in;
    logic [MAG_W:0]   u_sh, v_sh, d_ext, u_dif, v_dif;
    logic             u_ge, v_ge;

    if (k == 0) begin : g_first
      assign ru_in = in_umag;
      assign rv_in = in_vmag;
      assign dd_in = in_dmag;
      assign qu_in = '0;
      assign qv_in = '0;
      assign fl_in = in_flags;
    end else begin : g_next
      assign ru_in = ru_r[k-1];
      assign rv_in = rv_r[k-1];
      assign dd_in = dd_r[k-1];
      assign qu_in = qu_r[k-1];
      assign qv_in = qv_r[k-1];
      assign fl_in = fl_r[k-1];
    end

    // Shift the partial remainder and try to subtract the divisor.
    assign u_sh  = {ru_in, 1'b0};
    assign v_sh  = {rv_in, 1'b0};
    assign d_ext = {1'b0, dd_in};
    assign u_ge  = (u_sh >= d_ext);
    assign v_ge  = (v_sh >= d_ext);
    assign u_dif = u_sh - d_ext;
    assign v_dif = v_sh - d_ext;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        ru_r[k] <= u_ge ? u_dif[MAG_W-1:0] : u_sh[MAG_W-1:0];
        rv_r[k] <= v_ge ? v_dif[MAG_W-1:0] : v_sh[MAG_W-1:0];
        dd_r[k] <= dd_in;
        qu_r[k] <= {qu_in[NSTG-2:0], u_ge};
        qv_r[k] <= {qv_in[NSTG-2:0], v_ge};
        fl_r[k] <= fl_in;
      end
    end
  end

  assign out_qu    = qu_r[NSTG-1];
  assign out_qv    = qv_r[NSTG-1];
  assign out_flags = fl_r[NSTG-1];

`ifndef SYNTHESIS
  // Where the quotient is used, the remainder stays below the divisor.
  for (genvar k = 0; k < NSTG; k++) begin : g_chk
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[k] |->
        (fl_r[k].degen || fl_r[k].u_zero || fl_r[k].u_one || (ru_r[k] < dd_r[k])) &&
        (fl_r[k].degen || fl_r[k].v_zero || fl_r[k].v_one || (rv_r[k] < dd_r[k])))
      else $error("divider remainder not below divisor");
  end
`endif

endmodule

`default_nettype wire

/* rtl/caim_report.sv */
`default_nettype none

// Three stage back end: clipped ratio and offset, scale by full range,
// then truncation toward zero into the output register.
module caim_report (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [caim_pkg::QUOT_BITS-1:0]     in_qu,
  input  wire logic [caim_pkg::QUOT_BITS-1:0]     in_qv,
  input  wire caim_pkg::caim_flags_t              in_flags,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [caim_pkg::REPORT_W-1:0]    out_report_x,
  output logic signed [caim_pkg::REPORT_W-1:0]    out_report_y,
  output logic                                    out_degenerate
);
  import caim_pkg::*;

  localparam int NSTG  = 3;
  localparam int W_W   = QUOT_BITS + 1;
  localparam int S_W   = QUOT_BITS + 2;
  localparam int SW_W  = QUOT_BITS + 3;
  localparam int P_W   = 2 * QUOT_BITS + 1;
  localparam int SHIFT = $clog2(REPORT_FULL + 1);

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   en;
  logic [NSTG-1:0] v_in;

  assign en[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign v_in = {v_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  // Stage 1: pick the clipped ratio and form 2w - 1 in Q1.16.
  logic [W_W-1:0]         wu, wv;
  logic signed [SW_W-1:0] su_wide, sv_wide;
  logic signed [S_W-1:0]  su_r, sv_r;
  logic                   dg1_r;

  always_comb begin
    if (in_flags.degen || in_flags.u_zero) begin
      wu = '0;
    end else if (in_flags.u_one) begin
      wu = UNIT_Q;
    end else begin
      wu = {1'b0, in_qu};
    end
    if (in_flags.degen || in_flags.v_zero) begin
      wv = '0;
    end else if (in_flags.v_one) begin
      wv = UNIT_Q;
    end else begin
      wv = {1'b0, in_qv};
    end
    su_wide = $signed({1'b0, wu, 1'b0}) - $signed({2'b00, UNIT_Q});
    sv_wide = $signed({1'b0, wv, 1'b0}) - $signed({2'b00, UNIT_Q});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      su_r  <= su_wide[S_W-1:0];
      sv_r  <= sv_wide[S_W-1:0];
      dg1_r <= in_flags.degen;
    end
  end

  // Stage 2: multiply by the full scale as a shift and subtract.
  logic signed [P_W-1:0] pu_r, pv_r;
  logic                  dg2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pu_r  <= (P_W'(su_r) <<< SHIFT) - P_W'(su_r);
      pv_r  <= (P_W'(sv_r) <<< SHIFT) - P_W'(sv_r);
      dg2_r <= dg1_r;
    end
  end

  // Stage 3: divide by one in Q1.16, rounding negative values toward zero.
  logic signed [P_W-1:0] pu_b, pv_b;
  logic signed [P_W-1:0] bias;

  assign bias = P_W'(UNIT_Q) - P_W'(1);

  always_comb begin
    pu_b = pu_r + (pu_r[P_W-1] ? bias : '0);
    pv_b = pv_r + (pv_r[P_W-1] ? bias : '0);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_report_x   <= pu_b[QUOT_BITS +: REPORT_W];
      out_report_y   <= pv_b[QUOT_BITS +: REPORT_W];
      out_degenerate <= dg2_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/camera_to_screen_aim_mapper.sv */
`default_nettype none

// Channel   Handshake                  Payload
// in        in_valid / in_ready        origin, x-axis and y-axis marker col/row
// out       out_valid / out_ready      report_x, report_y, degenerate
// cfg       cfg_we (no wait)           cfg_index, cfg_wdata (aim_col, aim_row)
//
// One word per clock in and out while out_ready stays high. The pipeline has
// 5 front stages (offsets, products, determinant, magnitudes, clip compare),
// 16 divider stages at one quotient bit each, and 3 report stages.
// Reset (synchronous, rst_n low) empties every stage and loads the aim point.
// A stalled output holds; each stage still fills while it is empty, so the
// input keeps accepting words until the pipeline is full.
module camera_to_screen_aim_mapper #(
  parameter int COORD_BITS = caim_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [COORD_BITS-1:0]               in_origin_col,
  input  wire logic [COORD_BITS-1:0]               in_origin_row,
  input  wire logic [COORD_BITS-1:0]               in_xaxis_col,
  input  wire logic [COORD_BITS-1:0]               in_xaxis_row,
  input  wire logic [COORD_BITS-1:0]               in_yaxis_col,
  input  wire logic [COORD_BITS-1:0]               in_yaxis_row,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [caim_pkg::REPORT_W-1:0]     out_report_x,
  output logic signed [caim_pkg::REPORT_W-1:0]     out_report_y,
  output logic                                     out_degenerate,
  input  wire logic                                cfg_we,
  input  wire logic [caim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [caim_pkg::CFG_W-1:0]          cfg_wdata
);
  import caim_pkg::*;

  localparam int MAG_W = 2 * COORD_BITS + 1;

  // Aim point registers.
  logic [COORD_BITS-1:0] aim_col_r, aim_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aim_col_r <= COORD_BITS'(AIM_COL_RESET);
      aim_row_r <= COORD_BITS'(AIM_ROW_RESET);
    end else if (cfg_we) begin
      case (caim_cfg_idx_t'(cfg_index))
        CFG_AIM_COL: aim_col_r <= COORD_BITS'(cfg_wdata);
        CFG_AIM_ROW: aim_row_r <= COORD_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Front end to divider.
  logic             s_valid, s_ready;
  logic [MAG_W-1:0] s_dmag, s_umag, s_vmag;
  caim_flags_t      s_flags;

  caim_solve #(
    .COORD_BITS (COORD_BITS),
    .MAG_W      (MAG_W)
  ) u_solve (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .aim_col    (aim_col_r),
    .aim_row    (aim_row_r),
    .origin_col (in_origin_col),
    .origin_row (in_origin_row),
    .xaxis_col  (in_xaxis_col),
    .xaxis_row  (in_xaxis_row),
    .yaxis_col  (in_yaxis_col),
    .yaxis_row  (in_yaxis_row),
    .out_valid  (s_valid),
    .out_ready  (s_ready),
    .out_dmag   (s_dmag),
    .out_umag   (s_umag),
    .out_vmag   (s_vmag),
    .out_flags  (s_flags)
  );

  // Divider to report stages.
  logic                 d_valid, d_ready;
  logic [QUOT_BITS-1:0] d_qu, d_qv;
  caim_flags_t          d_flags;

  caim_divider #(
    .MAG_W (MAG_W)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_dmag   (s_dmag),
    .in_umag   (s_umag),
    .in_vmag   (s_vmag),
    .in_flags  (s_flags),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_qu    (d_qu),
    .out_qv    (d_qv),
    .out_flags (d_flags)
  );

  caim_report u_report (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (d_valid),
    .in_ready       (d_ready),
    .in_qu          (d_qu),
    .in_qv          (d_qv),
    .in_flags       (d_flags),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_report_x   (out_report_x),
    .out_report_y   (out_report_y),
    .out_degenerate (out_degenerate)
  );

`ifndef SYNTHESIS
  // A degenerate marker set reports the far negative edge on both axes.
  a_degen_forced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_report_x == -16'sd32767) && (out_report_y == -16'sd32767))
    else $error("degenerate word without forced reports");

  // Reports never reach the most negative code.
  a_report_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_report_x != -16'sd32768) && (out_report_y != -16'sd32768))
    else $error("report outside the symmetric range");
`endif

endmodule

`default_nettype wire
